// ----- rtl/ste_pkg.sv -----
// types, constants and lookup functions for the segment transition effects block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ste_pkg;

    localparam int FRAME_COUNT = 16;
    localparam int FRAME_W     = 5;
    localparam int CFG_DATA_W  = 3;
    localparam int CFG_INDEX_W = 2;

    localparam logic [7:0] POINT_BIT     = 8'h40;
    localparam logic [7:0] SEG_MASK      = 8'hbf;
    localparam logic [7:0] SOURCE_RESET  = 8'ha4;
    localparam logic [3:0] DIGIT_NONE    = 4'd10;

    // input kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_POINT = 2'd2;

    // effect modes
    localparam logic [1:0] MODE_STROKE = 2'd0;
    localparam logic [1:0] MODE_BLINK  = 2'd1;
    localparam logic [1:0] MODE_ROLL   = 2'd2;
    localparam logic [1:0] MODE_SLIP   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_EFFECT_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EFFECT_MODE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOUR_INDEX  = 2'd2;

    // ascii bounds
    localparam logic [7:0] ASCII_0 = 8'h30;
    localparam logic [7:0] ASCII_9 = 8'h39;
    localparam logic [7:0] ASCII_A = 8'h41;
    localparam logic [7:0] ASCII_Z = 8'h5a;
    localparam logic [7:0] ASCII_LA = 8'h61;
    localparam logic [7:0] ASCII_LZ = 8'h7a;
    localparam logic [7:0] LETTER_BASE = 8'd10;

    localparam logic [7:0] FONT [0:35] = '{
        8'hb7, 8'h22, 8'h9b, 8'hab, 8'h2e, 8'had, 8'hbd, 8'h23, 8'hbf, 8'haf,
        8'hbb, 8'hbc, 8'h98, 8'hba, 8'h9f, 8'h1d, 8'hb5, 8'h3c, 8'h14, 8'ha2,
        8'h9c, 8'h94, 8'h37, 8'h38, 8'hb8, 8'h1f, 8'h2f, 8'h18, 8'h2c, 8'h1c,
        8'hb0, 8'h90, 8'h0e, 8'h0f, 8'h2a, 8'h1a
    };

    localparam logic [7:0] ROLL_KEEP [0:3] = '{8'hbe, 8'hb8, 8'hb0, 8'h80};
    localparam logic [7:0] SLIP_KEEP [0:3] = '{8'hab, 8'hab, 8'h22, 8'h00};

    // seven segment numbers per digit, value 8 is an empty step
    localparam logic [3:0] STROKE_ORDER [0:69] = '{
        4'd2, 4'd4, 4'd7, 4'd5, 4'd1, 4'd8, 4'd0,
        4'd1, 4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd8,
        4'd7, 4'd4, 4'd8, 4'd3, 4'd8, 4'd1, 4'd0,
        4'd0, 4'd1, 4'd3, 4'd8, 4'd8, 4'd5, 4'd7,
        4'd5, 4'd1, 4'd8, 4'd8, 4'd3, 4'd8, 4'd2,
        4'd0, 4'd2, 4'd8, 4'd8, 4'd3, 4'd5, 4'd7,
        4'd0, 4'd2, 4'd8, 4'd4, 4'd7, 4'd5, 4'd3,
        4'd0, 4'd8, 4'd8, 4'd1, 4'd8, 4'd8, 4'd5,
        4'd1, 4'd0, 4'd2, 4'd4, 4'd7, 4'd5, 4'd3,
        4'd3, 4'd8, 4'd2, 4'd0, 4'd1, 4'd5, 4'd7
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
        logic       point_on;
    } ste_in_t;

    typedef struct packed {
        logic [7:0] segment_byte;
        logic [2:0] colour_byte;
    } ste_out_t;

    typedef struct packed {
        logic [7:0]         shown;
        logic [7:0]         source;
        logic [7:0]         target;
        logic [FRAME_W-1:0] frame;
    } ste_state_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] pattern;
    } ste_glyph_t;

    function automatic ste_glyph_t char_glyph(input logic [7:0] c);
        ste_glyph_t g;
        logic [7:0] idx;
        g.hit = 1'b0;
        g.pattern = 8'h00;
        idx = 8'h00;
        if (c inside {[ASCII_0:ASCII_9]}) begin
            idx = c - ASCII_0;
            g.hit = 1'b1;
        end else if (c inside {[ASCII_A:ASCII_Z]}) begin
            idx = c - ASCII_A + LETTER_BASE;
            g.hit = 1'b1;
        end else if (c inside {[ASCII_LA:ASCII_LZ]}) begin
            idx = c - ASCII_LA + LETTER_BASE;
            g.hit = 1'b1;
        end
        if (g.hit) begin
            g.pattern = FONT[idx[5:0]];
        end
        return g;
    endfunction

    // digit whose font byte equals the pattern, DIGIT_NONE otherwise
    function automatic logic [3:0] digit_of(input logic [7:0] p);
        logic [3:0] d;
        d = DIGIT_NONE;
        for (int i = 9; i >= 0; i--) begin
            if (FONT[i] == p) begin
                d = 4'(i);
            end
        end
        return d;
    endfunction

endpackage

// ----- rtl/segment_transition_effects.sv -----
// top level of the segment transition effects block: handshake, state and result register
// depends on ste_pkg and ste_effect
`timescale 1ns / 1ps

// One segment display digit with animated character changes. Every accepted item
// (character, effect tick or decimal point) gives exactly one result item holding the
// shown segment byte and the colour byte. An item is worked out in the cycle it is
// accepted and its result registered. The block takes one item per clock while the
// result side keeps up, and also accepts while a result waits if that result is taken
// in the same cycle. Configuration writes on the cfg port take effect from the next item;
// the user makes them while no item is in flight, as the block does not check this.
module segment_transition_effects import ste_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ste_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ste_out_t               m_data
);

    logic       effect_enable_reg;
    logic [1:0] effect_mode_reg;
    logic [2:0] colour_index_reg;

    ste_state_t state_reg;
    ste_state_t state_next;
    logic       m_valid_reg;
    ste_out_t   m_data_reg;
    logic       run_reg;

    logic       s_accept;
    ste_glyph_t glyph;
    logic [7:0] frame_shown;

    assign s_ready  = run_reg && (!m_valid_reg || m_ready);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign glyph = char_glyph(s_data.char_code);

    ste_effect u_effect (
        .state       (state_reg),
        .mode        (effect_mode_reg),
        .frame_shown (frame_shown)
    );

    always_comb begin
        state_next = state_reg;
        case (s_data.kind)
            KIND_CHAR: begin
                if (glyph.hit) begin
                    if (effect_enable_reg) begin
                        state_next.target = (state_reg.target & POINT_BIT) | glyph.pattern;
                    end else begin
                        state_next.shown = (state_reg.shown & POINT_BIT) | glyph.pattern;
                    end
                end
            end
            KIND_TICK: begin
                if (state_reg.source != state_reg.target) begin
                    if (state_reg.frame < FRAME_W'(FRAME_COUNT)) begin
                        state_next.shown = frame_shown;
                        state_next.frame = state_reg.frame + FRAME_W'(1);
                    end else begin
                        state_next.source = state_reg.target;
                        state_next.frame  = '0;
                        state_next.shown  = (state_reg.shown & POINT_BIT) | state_reg.target;
                    end
                end
            end
            KIND_POINT: begin
                state_next.shown = s_data.point_on ? (state_reg.shown | POINT_BIT)
                                                   : (state_reg.shown & SEG_MASK);
            end
            default: begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            effect_enable_reg <= 1'b1;
            effect_mode_reg   <= MODE_STROKE;
            colour_index_reg  <= 3'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_EFFECT_ENABLE: effect_enable_reg <= cfg_wdata[0];
                CFG_EFFECT_MODE:   effect_mode_reg   <= cfg_wdata[1:0];
                CFG_COLOUR_INDEX:  colour_index_reg  <= cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    // digit state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg          <= 1'b0;
            state_reg.shown  <= 8'h00;
            state_reg.source <= SOURCE_RESET;
            state_reg.target <= 8'h00;
            state_reg.frame  <= '0;
        end else begin
            run_reg <= 1'b1;
            if (s_accept) begin
                state_reg <= state_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg.segment_byte <= state_next.shown;
            m_data_reg.colour_byte  <= ~colour_index_reg;
        end
    end

endmodule

// ----- rtl/ste_effect.sv -----
// shown segment pattern for one transition frame in the selected effect mode
// depends on ste_pkg
`timescale 1ns / 1ps

module ste_effect import ste_pkg::*; (
    input  ste_state_t state,
    input  logic [1:0] mode,
    output logic [7:0] frame_shown
);

    logic [3:0] f;
    logic [3:0] d_src;
    logic [3:0] d_tgt;
    logic [2:0] pos;
    logic [6:0] order_idx;
    logic [3:0] seg;
    logic [7:0] cur;
    logic [7:0] stroke_shown;
    logic [1:0] mask_idx;
    logic [7:0] mask_base;
    logic [7:0] mask;

    assign f     = state.frame[3:0];
    assign d_src = digit_of(state.source);
    assign d_tgt = digit_of(state.target);

    // stroke: remove old segments on frames 0-6, add new ones on frames 9-15
    always_comb begin
        cur = state.shown & SEG_MASK;
        stroke_shown = state.shown;
        pos = 3'd0;
        order_idx = 7'd0;
        seg = 4'd8;
        if (f < 4'd7) begin
            pos = 3'(4'd6 - f);
            order_idx = 7'(d_src) * 7'd7 + 7'(pos);
            if (d_src != DIGIT_NONE) begin
                seg = STROKE_ORDER[order_idx];
                if (!seg[3]) begin
                    cur = cur & ~(8'h01 << seg[2:0]);
                end
                stroke_shown = (state.shown & POINT_BIT) | cur;
            end
        end else if (f > 4'd8) begin
            pos = 3'(f - 4'd9);
            order_idx = 7'(d_tgt) * 7'd7 + 7'(pos);
            if (d_tgt != DIGIT_NONE) begin
                seg = STROKE_ORDER[order_idx];
                if (!seg[3]) begin
                    cur = cur | (8'h01 << seg[2:0]);
                end
                stroke_shown = (state.shown & POINT_BIT) | cur;
            end
        end
    end

    // roll and slip: first half masks source, second half unmasks target
    assign mask_idx  = f[3] ? ~f[2:1] : f[2:1];
    assign mask_base = f[3] ? state.target : state.source;
    assign mask      = (mode == MODE_ROLL) ? ROLL_KEEP[mask_idx] : SLIP_KEEP[mask_idx];

    always_comb begin
        case (mode)
            MODE_STROKE: begin
                frame_shown = stroke_shown;
            end
            MODE_BLINK: begin
                frame_shown = (state.shown & POINT_BIT)
                            | (f[1] ? state.target : state.source);
            end
            MODE_ROLL, MODE_SLIP: begin
                frame_shown = (state.shown & POINT_BIT) | (mask_base & mask);
            end
            default: begin
                frame_shown = state.shown;
            end
        endcase
    end

endmodule

// ----- rtl/ste_checker.sv -----
// port-level checks for the segment transition effects block, bound to the top level
// depends on ste_pkg and segment_transition_effects
`timescale 1ns / 1ps

module ste_checker import ste_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input ste_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input ste_out_t m_data
);

    // every accepted item gives a result in the next cycle
    a_item_result: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && s_valid && s_ready |=> m_valid)
        else $error("accepted item gave no result");

    // a waiting result is held until taken
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // output side empty or draining means input can be taken
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && $past(aresetn) && (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled with free result register");

    // decimal point item shows up in bit 6 of its result
    a_point: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && s_valid && s_ready && s_data.kind == KIND_POINT
        |=> m_data.segment_byte[6] == $past(s_data.point_on))
        else $error("decimal point not applied");

endmodule

bind segment_transition_effects ste_checker u_ste_checker (.*);

// ----- bench/segment_transition_effects_tb.sv -----
// self-checking testbench for segment_transition_effects: directed table, then random
// character/tick sequences checked against an in-bench display predictor; needs ste_pkg
`timescale 1ns / 1ps

module segment_transition_effects_tb;
    import ste_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          FRAMES      = 16;
    localparam int          NO_SEG      = 8;
    localparam int          NO_GLYPH    = 36;
    localparam int          NO_DIGIT    = 10;
    localparam logic [7:0]  PT_BIT      = 8'h40;
    localparam logic [7:0]  SEG_BITS    = 8'hbf;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [7:0] GLYPHS [0:35] = '{
        8'hb7, 8'h22, 8'h9b, 8'hab, 8'h2e, 8'had, 8'hbd, 8'h23, 8'hbf, 8'haf,
        8'hbb, 8'hbc, 8'h98, 8'hba, 8'h9f, 8'h1d, 8'hb5, 8'h3c, 8'h14, 8'ha2,
        8'h9c, 8'h94, 8'h37, 8'h38, 8'hb8, 8'h1f, 8'h2f, 8'h18, 8'h2c, 8'h1c,
        8'hb0, 8'h90, 8'h0e, 8'h0f, 8'h2a, 8'h1a
    };
    localparam logic [7:0] ROLL_KEEPS [0:3] = '{8'hbe, 8'hb8, 8'hb0, 8'h80};
    localparam logic [7:0] SLIP_KEEPS [0:3] = '{8'hab, 8'hab, 8'h22, 8'h00};
    localparam logic [3:0] STROKE_SEQ [0:69] = '{
        4'd2, 4'd4, 4'd7, 4'd5, 4'd1, 4'd8, 4'd0,
        4'd1, 4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd8,
        4'd7, 4'd4, 4'd8, 4'd3, 4'd8, 4'd1, 4'd0,
        4'd0, 4'd1, 4'd3, 4'd8, 4'd8, 4'd5, 4'd7,
        4'd5, 4'd1, 4'd8, 4'd8, 4'd3, 4'd8, 4'd2,
        4'd0, 4'd2, 4'd8, 4'd8, 4'd3, 4'd5, 4'd7,
        4'd0, 4'd2, 4'd8, 4'd4, 4'd7, 4'd5, 4'd3,
        4'd0, 4'd8, 4'd8, 4'd1, 4'd8, 4'd8, 4'd5,
        4'd1, 4'd0, 4'd2, 4'd4, 4'd7, 4'd5, 4'd3,
        4'd3, 4'd8, 4'd2, 4'd0, 4'd1, 4'd5, 4'd7
    };

    // one directed row: a register write or an item, with an optional fixed result
    typedef struct packed {
        logic       is_cfg;
        logic [1:0] sel;
        logic [7:0] val;
        logic       pt;
        logic       typed;
        logic [7:0] seg;
        logic [2:0] col;
    } plan_row_t;

    localparam int PLAN_LEN = 30;
    localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
        '{1'b0, KIND_POINT,        8'h00,       1'b0, 1'b1, 8'h00, 3'd7},
        '{1'b0, KIND_POINT,        8'h00,       1'b1, 1'b1, 8'h40, 3'd7},
        '{1'b0, KIND_CHAR,         8'h00,       1'b1, 1'b1, 8'h40, 3'd7},
        '{1'b0, KIND_CHAR,         8'hff,       1'b0, 1'b1, 8'h40, 3'd7},
        '{1'b0, KIND_UNUSED,       8'hff,       1'b1, 1'b1, 8'h40, 3'd7},
        '{1'b0, KIND_CHAR,         ASCII_9,     1'b0, 1'b1, 8'h40, 3'd7},
        '{1'b0, KIND_TICK,         8'h00,       1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b0, KIND_TICK,         8'hff,       1'b1, 1'b0, 8'h00, 3'd0},
        '{1'b0, KIND_TICK,         8'h00,       1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b1, CFG_EFFECT_ENABLE, 8'h00,       1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b0, KIND_CHAR,         ASCII_LZ,    1'b0, 1'b1, 8'h5a, 3'd7},
        '{1'b0, KIND_CHAR,         ASCII_A,     1'b0, 1'b1, 8'hfb, 3'd7},
        '{1'b0, KIND_CHAR,         ASCII_0,     1'b0, 1'b1, 8'hf7, 3'd7},
        '{1'b1, CFG_COLOUR_INDEX,  8'h07,       1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b1, CFG_UNUSED,        8'h07,       1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b0, KIND_POINT,        8'h00,       1'b0, 1'b1, 8'hb7, 3'd0},
        '{1'b1, CFG_EFFECT_ENABLE, 8'h01,       1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b1, CFG_EFFECT_MODE,   {6'd0, MODE_BLINK}, 1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b0, KIND_CHAR,         ASCII_LA,    1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b0, KIND_TICK,         8'h00,       1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b0, KIND_TICK,         8'h00,       1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b0, KIND_TICK,         8'h00,       1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b1, CFG_EFFECT_MODE,   {6'd0, MODE_ROLL}, 1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b0, KIND_TICK,         8'h00,       1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b0, KIND_TICK,         8'h00,       1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b0, KIND_CHAR,         ASCII_Z,     1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b0, KIND_TICK,         8'h00,       1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b0, KIND_TICK,         8'h00,       1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b1, CFG_EFFECT_MODE,   {6'd0, MODE_SLIP}, 1'b0, 1'b0, 8'h00, 3'd0},
        '{1'b0, KIND_TICK,         8'h00,       1'b0, 1'b0, 8'h00, 3'd0}
    };

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    ste_in_t                s_data;
    logic                   m_valid;
    logic                   m_ready;
    ste_out_t               m_data;

    // predicted display state and register copies
    logic [7:0]         disp_shown  = 8'h00;
    logic [7:0]         disp_source = SOURCE_RESET;
    logic [7:0]         disp_target = 8'h00;
    logic [FRAME_W-1:0] disp_frame  = '0;
    logic               anim_on     = 1'b1;
    logic [1:0]         anim_mode   = MODE_STROKE;
    logic [2:0]         colour_sel  = 3'd0;

    ste_out_t display_q [$];
    ste_out_t due;
    int       mismatches  = 0;
    int       cycle_count = 0;
    int       sent        = 0;
    bit       quiet       = 1'b0;

    segment_transition_effects DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int glyph_index(input logic [7:0] c);
        if (c >= ASCII_0 && c <= ASCII_9) return int'(c) - int'(ASCII_0);
        if (c >= ASCII_A && c <= ASCII_Z) return int'(c) - int'(ASCII_A) + 10;
        if (c >= ASCII_LA && c <= ASCII_LZ) return int'(c) - int'(ASCII_LA) + 10;
        return NO_GLYPH;
    endfunction

    function automatic int digit_match(input logic [7:0] p);
        for (int i = 0; i < 10; i++) begin
            if (GLYPHS[i] == p) return i;
        end
        return NO_DIGIT;
    endfunction

    function automatic void show_segments(input logic [7:0] p);
        disp_shown = (disp_shown & PT_BIT) | p;
    endfunction

    function automatic void stroke_frame();
        int         f;
        int         d;
        int         seg;
        logic [7:0] cur;
        f = int'(disp_frame);
        cur = disp_shown & SEG_BITS;
        if (f < 7) begin
            d = digit_match(disp_source);
            if (d == NO_DIGIT) return;
            seg = int'(STROKE_SEQ[7 * d + 6 - f]);
            if (seg < NO_SEG) cur[seg] = 1'b0;
        end else if (f > 8 && f < FRAMES) begin
            d = digit_match(disp_target);
            if (d == NO_DIGIT) return;
            seg = int'(STROKE_SEQ[7 * d + f - 9]);
            if (seg < NO_SEG) cur[seg] = 1'b1;
        end else begin
            return;
        end
        show_segments(cur);
    endfunction

    function automatic void masked_frame(input bit slip);
        int         f;
        int         m;
        logic [7:0] base;
        f = int'(disp_frame) % FRAMES;
        if (f < 8) begin
            m = f / 2;
            base = disp_source;
        end else begin
            m = 7 - f / 2;
            base = disp_target;
        end
        show_segments(base & (slip ? SLIP_KEEPS[m] : ROLL_KEEPS[m]));
    endfunction

    function automatic void advance_frame();
        if (disp_source == disp_target) return;
        if (disp_frame < FRAMES) begin
            case (anim_mode)
                MODE_STROKE: stroke_frame();
                MODE_BLINK:  show_segments(disp_frame[1] ? disp_target : disp_source);
                MODE_ROLL:   masked_frame(1'b0);
                default:     masked_frame(1'b1);
            endcase
            disp_frame = disp_frame + FRAME_W'(1);
        end else begin
            disp_source = disp_target;
            disp_frame = '0;
            show_segments(disp_target);
        end
    endfunction

    function automatic ste_out_t step_display(input ste_in_t item);
        ste_out_t res;
        int       gi;
        case (item.kind)
            KIND_CHAR: begin
                gi = glyph_index(item.char_code);
                if (gi < NO_GLYPH) begin
                    if (anim_on) disp_target = (disp_target & PT_BIT) | GLYPHS[gi];
                    else show_segments(GLYPHS[gi]);
                end
            end
            KIND_TICK:  advance_frame();
            KIND_POINT: disp_shown[6] = item.point_on;
            default: ;
        endcase
        res.segment_byte = disp_shown;
        res.colour_byte = 3'd7 - colour_sel;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    // sends one item, then records its expected result at the accepting edge
    task automatic send_item(input ste_in_t item, input logic typed, input ste_out_t fixed);
        ste_out_t res;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        res = step_display(item);
        display_q.push_back(typed ? fixed : res);
        sent++;
    endtask

    task automatic send_fields(input logic [1:0] kind, input logic [7:0] code, input logic pt);
        ste_in_t item;
        item.kind = kind;
        item.char_code = code;
        item.point_on = pt;
        send_item(item, 1'b0, '0);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (display_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_EFFECT_ENABLE: anim_on = data[0];
            CFG_EFFECT_MODE:   anim_mode = data[1:0];
            CFG_COLOUR_INDEX:  colour_sel = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1:    return ASCII_A + 8'($urandom_range(0, 25));
            2:       return ASCII_LA + 8'($urandom_range(0, 25));
            default: return ASCII_0 + 8'($urandom_range(0, 9));
        endcase
    endfunction

    // one well-formed change: a character and enough ticks to mostly finish it
    task automatic send_transition();
        int ticks;
        send_fields(KIND_CHAR, pick_char(), 1'($urandom_range(0, 1)));
        ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(17, 20);
        for (int t = 0; t < ticks; t++) begin
            case ($urandom_range(0, 19))
                0:       send_fields(KIND_POINT, 8'($urandom), 1'($urandom_range(0, 1)));
                1:       send_fields(KIND_CHAR, pick_char(), 1'($urandom_range(0, 1)));
                default: send_fields(KIND_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    // result side with random stall bursts
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (display_q.size() == 0) begin
                report_mismatch("unexpected item", m_data.segment_byte, 8'h00);
            end else begin
                due = display_q.pop_front();
                if (m_data.segment_byte !== due.segment_byte)
                    report_mismatch("segment_byte", m_data.segment_byte, due.segment_byte);
                if (m_data.colour_byte !== due.colour_byte)
                    report_mismatch("colour_byte", 8'(m_data.colour_byte),
                                    8'(due.colour_byte));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        ste_in_t  item;
        ste_out_t fixed;
        int       target_sent;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < PLAN_LEN; r++) begin
            if (PLAN[r].is_cfg) begin
                drain();
                write_reg(PLAN[r].sel, PLAN[r].val[CFG_DATA_W-1:0]);
            end else begin
                item.kind = PLAN[r].sel;
                item.char_code = PLAN[r].val;
                item.point_on = PLAN[r].pt;
                fixed.segment_byte = PLAN[r].seg;
                fixed.colour_byte = PLAN[r].col;
                send_item(item, PLAN[r].typed, fixed);
            end
        end

        for (int phase = 0; phase < 10; phase++) begin
            drain();
            quiet = (phase == 4 || phase >= 8);
            write_reg(CFG_EFFECT_ENABLE,
                      CFG_DATA_W'((phase == 3 || $urandom_range(0, 5) == 0) ? 0 : 1));
            write_reg(CFG_EFFECT_MODE,
                      CFG_DATA_W'((phase < 4) ? phase : $urandom_range(0, 3)));
            write_reg(CFG_COLOUR_INDEX,
                      CFG_DATA_W'((phase == 0) ? 0 : (phase == 1) ? 7
                                                 : $urandom_range(0, 7)));
            if (phase == 2) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 7)));
            target_sent = sent + 40;
            while (sent < target_sent) begin
                if ($urandom_range(0, 4) == 0)
                    send_fields(2'($urandom_range(0, 3)), 8'($urandom),
                                1'($urandom_range(0, 1)));
                else
                    send_transition();
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
